// ===== rtl/cfdm_pkg.sv =====
// Shared constants and types for the coprime filter with divisor marks.
package cfdm_pkg;

    localparam int MAX_VALUE = 131071;
    localparam int VAL_W     = 17;
    localparam int ROW_BITS  = 5;
    localparam int ROW_W     = 1 << ROW_BITS;
    localparam int ROWS      = (MAX_VALUE + 1) / ROW_W;
    localparam int ROW_AW    = $clog2(ROWS);
    localparam int J_W       = 9;
    localparam int SQ_W      = 18;
    localparam int CNT_W     = 5;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(VAL_W - 1);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quo;
        logic [J_W-1:0]   rem;
    } t_div_res;

endpackage

// ===== rtl/cfdm_div.sv =====
// Restoring divider that yields one quotient bit per cycle.
module cfdm_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [cfdm_pkg::VAL_W-1:0] i_dividend,
    input  logic [cfdm_pkg::J_W-1:0]   i_divisor,
    output cfdm_pkg::t_div_res         o_res
);
    import cfdm_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0] r_dvd;
    logic [VAL_W-1:0] r_quo;
    logic [J_W-1:0]   r_rem;
    logic [J_W:0]     w_sh;
    logic             w_ge;
    logic [J_W:0]     w_sub;

    assign w_sh  = {r_rem, r_dvd[VAL_W-1]};
    assign w_ge  = (w_sh >= {1'b0, i_divisor});
    assign w_sub = w_sh - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[VAL_W-2:0], 1'b0};
            r_quo <= {r_quo[VAL_W-2:0], w_ge};
            r_rem <= w_ge ? w_sub[J_W-1:0] : w_sh[J_W-1:0];
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

endmodule

// ===== rtl/coprime_filter_divisor_marks.sv =====
// Top level of the coprime filter that keeps one mark bit per integer.
// Each trial j is divided; on a zero remainder the marks of j and its quotient follow.
// A load or query runs j from 1 to floor(sqrt(value)); a query ends early on a mark.
// Queries at zero or beyond the limit skip the trial divisors and go straight to output.
// A clear zeroes all 4096 rows; the next transaction is taken once the current one ends.
// After reset all 4096 rows of the mark memory are swept clear and the limit is 131071.
module coprime_filter_divisor_marks (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_op,
    input  logic [cfdm_pkg::VAL_W-1:0] i_operand_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [cfdm_pkg::VAL_W-1:0] o_tested_value,
    output logic                       o_coprime,
    output logic                       o_beyond_limit,
    input  logic                       i_cfg_we,
    input  logic [cfdm_pkg::VAL_W-1:0] i_cfg_data
);
    import cfdm_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CLEAR = 10'b0000000010,
        S_CHK   = 10'b0000000100,
        S_DIV   = 10'b0000001000,
        S_RD1   = 10'b0000010000,
        S_WB1   = 10'b0000100000,
        S_RD2   = 10'b0001000000,
        S_WB2   = 10'b0010000000,
        S_NEXT  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [VAL_W-1:0]  r_lim;
    logic [J_W-1:0]    r_j, n_j;
    logic [SQ_W-1:0]   r_jsq, n_jsq;
    logic [VAL_W-1:0]  r_q, n_q;
    logic [ROW_AW-1:0] r_ccnt, n_ccnt;
    logic              r_cop, n_cop;
    logic              r_bl, n_bl;
    logic              r_ovalid, n_ovalid;
    logic [VAL_W-1:0]  r_oval;
    logic              r_ocop, r_obl;
    logic              w_oload;

    logic [ROW_W-1:0]  mem [ROWS];
    logic [ROW_W-1:0]  r_rdata;
    logic              w_we;
    logic [ROW_AW-1:0] w_waddr, w_raddr;
    logic [ROW_W-1:0]  w_wdata;
    logic [ROW_AW-1:0] w_rowj, w_rowq;

    logic     w_start;
    t_div_res w_div;

    cfdm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_val),
        .i_divisor  (r_j),
        .o_res      (w_div)
    );

    assign w_rowj  = ROW_AW'(r_j >> ROW_BITS);
    assign w_rowq  = ROW_AW'(r_q >> ROW_BITS);
    assign w_raddr = (r_state == S_RD1) ? w_rowj : w_rowq;
    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_val    = r_val;
        n_j      = r_j;
        n_jsq    = r_jsq;
        n_q      = r_q;
        n_ccnt   = r_ccnt;
        n_cop    = r_cop;
        n_bl     = r_bl;
        w_start  = 1'b0;
        w_we     = 1'b0;
        w_waddr  = w_rowj;
        w_wdata  = r_rdata;
        w_oload  = 1'b0;
        n_ovalid = r_ovalid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op  = t_op'(i_op);
                    n_val = i_operand_value;
                    n_j   = J_W'(1);
                    n_jsq = SQ_W'(1);
                    n_cop = 1'b1;
                    n_bl  = 1'b0;
                    case (t_op'(i_op))
                        OP_LOAD: n_state = S_CHK;
                        OP_QUERY: begin
                            if (i_operand_value > r_lim) begin
                                n_cop   = 1'b0;
                                n_bl    = 1'b1;
                                n_state = S_OUT;
                            end else if (i_operand_value == '0) begin
                                n_cop   = 1'b0;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_CHK;
                            end
                        end
                        OP_CLEAR: begin
                            n_ccnt  = '0;
                            n_state = S_CLEAR;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_ccnt;
                w_wdata = '0;
                n_ccnt  = r_ccnt + 1'b1;
                if (r_ccnt == ROW_AW'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_CHK: begin
                if (r_jsq > {1'b0, r_val}) begin
                    n_state = (r_op == OP_QUERY) ? S_OUT : S_IDLE;
                end else begin
                    w_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    n_q     = w_div.quo;
                    n_state = (w_div.rem == '0) ? S_RD1 : S_NEXT;
                end
            end
            S_RD1: n_state = S_WB1;
            S_WB1: begin
                n_state = S_RD2;
                if (r_j > J_W'(1)) begin
                    if (r_op == OP_LOAD) begin
                        w_we    = 1'b1;
                        w_waddr = w_rowj;
                        w_wdata = r_rdata | (ROW_W'(1) << r_j[ROW_BITS-1:0]);
                    end else if (r_rdata[r_j[ROW_BITS-1:0]]) begin
                        n_cop   = 1'b0;
                        n_state = S_OUT;
                    end
                end
            end
            S_RD2: n_state = S_WB2;
            S_WB2: begin
                n_state = S_NEXT;
                if (r_q > VAL_W'(1)) begin
                    if (r_op == OP_LOAD) begin
                        w_we    = 1'b1;
                        w_waddr = w_rowq;
                        w_wdata = r_rdata | (ROW_W'(1) << r_q[ROW_BITS-1:0]);
                    end else if (r_rdata[r_q[ROW_BITS-1:0]]) begin
                        n_cop   = 1'b0;
                        n_state = S_OUT;
                    end
                end
            end
            S_NEXT: begin
                n_j     = r_j + 1'b1;
                n_jsq   = r_jsq + {{(SQ_W-J_W-1){1'b0}}, r_j, 1'b1};
                n_state = S_CHK;
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    w_oload  = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ccnt   <= '0;
            r_ovalid <= 1'b0;
            r_lim    <= VAL_W'(MAX_VALUE);
            r_op     <= OP_NONE;
        end else begin
            r_state  <= n_state;
            r_ccnt   <= n_ccnt;
            r_ovalid <= n_ovalid;
            r_op     <= n_op;
            if (i_cfg_we) begin
                r_lim <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_j   <= n_j;
        r_jsq <= n_jsq;
        r_q   <= n_q;
        r_cop <= n_cop;
        r_bl  <= n_bl;
        if (w_oload) begin
            r_oval <= r_val;
            r_ocop <= r_cop;
            r_obl  <= r_bl;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_tested_value = r_oval;
    assign o_coprime      = r_ocop;
    assign o_beyond_limit = r_obl;

`ifndef NO_ASSERTIONS
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("transaction accepted during the clearing sweep");
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (w_div.rem < r_j))
        else $error("divider remainder not below divisor");
    a_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (r_jsq == SQ_W'(r_j) * SQ_W'(r_j)))
        else $error("running square out of step with trial divisor");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_tested_value)))
        else $error("stalled result lost");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the coprime filter with divisor marks.
`timescale 1ns / 1ps

module tb_top;
    import cfdm_pkg::*;

    localparam int IDLE_LIMIT   = 100000;
    localparam int SETTLE_WAIT  = 8000;
    localparam int LONG_HOLD    = 3000;
    localparam int RANDOM_ITEMS = 650;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             coprime;
        logic             beyond;
    } t_coprime_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [1:0]       i_op = OP_NONE;
    logic [VAL_W-1:0] i_operand_value = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [VAL_W-1:0] o_tested_value;
    logic             o_coprime;
    logic             o_beyond_limit;
    logic             i_cfg_we = 1'b0;
    logic [VAL_W-1:0] i_cfg_data = '0;

    logic             marks [0:MAX_VALUE];
    logic [VAL_W-1:0] limit_model;
    t_coprime_result  pending_results[$];
    int               fail_count = 0;
    int               idle_cycles = 0;
    int               burst_left = 0;
    bit               gaps_on = 1'b1;
    bit               hold_req = 1'b0;
    int               hold_cnt = 0;
    int               rx_phase = 0;
    int               n_loads = 0;
    int               n_queries = 0;
    int               n_clears = 0;
    int               n_checked = 0;

    coprime_filter_divisor_marks u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_operand_value (i_operand_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_tested_value  (o_tested_value),
        .o_coprime       (o_coprime),
        .o_beyond_limit  (o_beyond_limit),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit marked(int d);
        if (d <= 1 || d > MAX_VALUE) begin
            return 1'b0;
        end
        return marks[d];
    endfunction

    task automatic apply_transaction(t_op op, logic [VAL_W-1:0] v);
        int              a;
        int              j;
        int              lim;
        t_coprime_result res;
        a = v;
        case (op)
            OP_LOAD: begin
                n_loads++;
                for (j = 1; j * j <= a; j++) begin
                    if (a % j == 0) begin
                        if (j > 1) marks[j] = 1'b1;
                        if (a / j > 1) marks[a / j] = 1'b1;
                    end
                end
            end
            OP_CLEAR: begin
                n_clears++;
                for (j = 0; j <= MAX_VALUE; j++) marks[j] = 1'b0;
            end
            OP_QUERY: begin
                n_queries++;
                lim = (limit_model > MAX_VALUE) ? MAX_VALUE : limit_model;
                res.value   = v;
                res.coprime = 1'b0;
                res.beyond  = 1'b0;
                if (a > lim) begin
                    res.beyond = 1'b1;
                end else if (a != 0) begin
                    res.coprime = 1'b1;
                    for (j = 1; j * j <= a; j++) begin
                        if (a % j == 0 && (marked(j) || marked(a / j))) begin
                            res.coprime = 1'b0;
                        end
                    end
                end
                pending_results.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic send_item(t_op op, logic [VAL_W-1:0] v);
        int gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                gap = $urandom_range(1, 20);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left--;
        end
        i_in_valid      <= 1'b1;
        i_op            <= op;
        i_operand_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
        apply_transaction(op, v);
    endtask

    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [VAL_W-1:0] v);
        drain_and_settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        limit_model = v;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return VAL_W'($urandom_range(1, 1023));
        if (r < 97) return VAL_W'($urandom_range(1, 16383));
        return VAL_W'($urandom_range(0, MAX_VALUE));
    endfunction

    function automatic t_op pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 33) return OP_LOAD;
        if (r < 94) return OP_QUERY;
        if (r < 97) return OP_CLEAR;
        return OP_NONE;
    endfunction

    task automatic test_directed();
        gaps_on = 1'b0;
        send_item(OP_QUERY, 17'd1);
        send_item(OP_QUERY, 17'd0);
        send_item(OP_QUERY, 17'd131071);
        send_item(OP_LOAD, 17'd0);
        send_item(OP_LOAD, 17'd1);
        send_item(OP_QUERY, 17'd12);
        send_item(OP_LOAD, 17'd12);
        send_item(OP_QUERY, 17'd18);
        send_item(OP_QUERY, 17'd35);
        send_item(OP_QUERY, 17'd1);
        send_item(OP_NONE, 17'd6);
        send_item(OP_QUERY, 17'd9);
        send_item(OP_LOAD, 17'd131071);
        send_item(OP_QUERY, 17'd131071);
        send_item(OP_LOAD, 17'd131070);
        send_item(OP_QUERY, 17'd65535);
        send_item(OP_CLEAR, 17'd0);
        send_item(OP_QUERY, 17'd18);
        send_item(OP_QUERY, 17'd131070);
        gaps_on = 1'b1;
    endtask

    task automatic test_limits();
        write_limit(17'd0);
        send_item(OP_QUERY, 17'd1);
        send_item(OP_QUERY, 17'd0);
        write_limit(17'd1);
        send_item(OP_QUERY, 17'd1);
        send_item(OP_QUERY, 17'd2);
        send_item(OP_LOAD, 17'd30);
        write_limit(17'd1000);
        repeat (30) send_item(pick_op(), VAL_W'($urandom_range(0, 2000)));
        write_limit(17'd131071);
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (40) send_item(OP_QUERY, VAL_W'($urandom_range(1, 63)));
    endtask

    task automatic test_random();
        int i;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) drain_and_settle();
            if (i % 200 == 100) gaps_on = !gaps_on;
            send_item(pick_op(), pick_value());
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            i_out_ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req) begin
            i_out_ready <= 1'b0;
            hold_cnt <= LONG_HOLD;
            hold_req <= 1'b0;
        end else begin
            rx_phase <= rx_phase + 1;
            i_out_ready <= rx_phase[9] ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_coprime_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction, tested_value %0d", o_tested_value);
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                n_checked++;
                if (o_tested_value !== exp_res.value) begin
                    $error("tested_value: expected %0d, actual %0d",
                           exp_res.value, o_tested_value);
                    fail_count++;
                end
                if (o_coprime !== exp_res.coprime) begin
                    $error("coprime: expected %0d, actual %0d", exp_res.coprime, o_coprime);
                    fail_count++;
                end
                if (o_beyond_limit !== exp_res.beyond) begin
                    $error("beyond_limit: expected %0d, actual %0d",
                           exp_res.beyond, o_beyond_limit);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int j;
        for (j = 0; j <= MAX_VALUE; j++) marks[j] = 1'b0;
        limit_model = 17'd131071;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_limits();
        test_backpressure();
        test_random();
        drain_and_settle();
        $display("Covered %0d loads, %0d queries and %0d clears; %0d results checked.",
                 n_loads, n_queries, n_clears, n_checked);
        $display("Limits 0, 1, 1000 and 131071 were exercised with back-pressure and pauses.");
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
